[sv/nps_pkg.sv]
// Package with the widths, codes and types shared by the nine-point stencil block.
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int SAMPLE_BITS  = 32;
	localparam int RESULT_BITS  = SAMPLE_BITS + 6;
	localparam int COL_BITS     = $clog2(MAX_WIDTH);
	localparam int W_BITS       = 11;
	localparam int H_BITS       = 13;
	localparam int ROW_BITS     = H_BITS;
	localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_INDEX_BITS = 1;
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int OCC_BITS     = FIFO_AW + 1;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [RESULT_BITS-1:0] result_t;

	// Which neighbors of the emitted point lie inside the grid.
	typedef struct packed {
		logic use_top;
		logic use_bot;
		logic use_left;
		logic use_right;
		logic last;
	} edge_flags_t;

	// One line memory entry: the column's samples from the two rows above.
	typedef struct packed {
		sample_t upper;
		sample_t middle;
	} line_pair_t;

	typedef struct packed {
		logic    last;
		result_t value;
	} out_beat_t;

	function automatic result_t sext(input sample_t v);
		return RESULT_BITS'(v);
	endfunction

endpackage
`default_nettype wire

[sv/nine_point_stencil_2d.sv]
// Top level of the streaming 3x3 nine-point stencil with line memory and output queue.
// A result passes the stage 1, window, stage 3 and stage 4 registers and the queue.
// Throughput: one input beat per cycle while s_tready is high; an entry is written back
// in the next cycle; back-to-back beats share a column only at a frame restart (rows masked).
// Reset: frame position restarts, frame width and height go to 1024, the output queue
// empties. The line memory is not cleared; its stale contents are masked at the grid edges.
`timescale 1ns / 1ps
`default_nettype none
module nine_point_stencil_2d (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [nps_pkg::S_TDATA_BITS-1:0]   s_tdata,  // [31:0] sample_value
	input  wire logic                               s_tuser,  // [0] operation
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [nps_pkg::M_TDATA_BITS-1:0]   m_tdata,  // [37:0] result_value, zero fill
	output      logic                               m_tlast,
	input  wire logic                               cfg_we,
	input  wire logic [nps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [nps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	// Configuration, stored already clamped.
	logic [nps_pkg::W_BITS-1:0]   w_q;
	logic [nps_pkg::H_BITS-1:0]   h_q;
	logic [nps_pkg::COL_BITS-1:0] col_q;
	logic [nps_pkg::ROW_BITS-1:0] row_q;
	logic [nps_pkg::OCC_BITS-1:0] occ_q;

	logic [nps_pkg::W_BITS-1:0] w_wr;
	logic [nps_pkg::H_BITS-1:0] h_wr;

	// Input stage.
	logic                          in_acc;
	logic                          drain;
	logic                          take;
	nps_pkg::sample_t              x_in;
	logic [nps_pkg::COL_BITS-1:0]  j;
	logic [nps_pkg::W_BITS-1:0]    col_inc;
	logic [nps_pkg::ROW_BITS-1:0]  r;
	logic [nps_pkg::COL_BITS-1:0]  c;
	logic                          emit;
	nps_pkg::edge_flags_t          flags;

	nps_pkg::line_pair_t line_mem [nps_pkg::MAX_WIDTH];

	logic                         valid_s1;
	logic                         emit_s1;
	nps_pkg::edge_flags_t         flags_s1;
	nps_pkg::sample_t             x_s1;
	logic [nps_pkg::COL_BITS-1:0] addr_s1;
	nps_pkg::line_pair_t          rd_s1;

	nps_pkg::sample_t win_q [9];

	logic                 valid_s2;
	nps_pkg::edge_flags_t flags_s2;

	logic             valid_s3;
	logic             last_s3;
	nps_pkg::result_t top_s3;
	nps_pkg::result_t bot_s3;
	nps_pkg::result_t side_s3;
	nps_pkg::result_t cent_s3;

	logic             valid_s4;
	logic             last_s4;
	nps_pkg::result_t a_s4;
	nps_pkg::result_t b_s4;

	nps_pkg::result_t t_tl, t_t, t_tr, t_l, t_c, t_r, t_bl, t_b, t_br;

	nps_pkg::out_beat_t          fifo_q [nps_pkg::FIFO_DEPTH];
	logic [nps_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [nps_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [nps_pkg::OCC_BITS-1:0] cnt_q;
	logic                         out_acc;

	// Clamp the written dimensions.
	always_comb begin
		if (cfg_data[nps_pkg::W_BITS-1:0] < nps_pkg::W_BITS'(2)) begin
			w_wr = nps_pkg::W_BITS'(2);
		end else if (cfg_data[nps_pkg::W_BITS-1:0] > nps_pkg::W_BITS'(nps_pkg::MAX_WIDTH)) begin
			w_wr = nps_pkg::W_BITS'(nps_pkg::MAX_WIDTH);
		end else begin
			w_wr = cfg_data[nps_pkg::W_BITS-1:0];
		end
		if (cfg_data[nps_pkg::H_BITS-1:0] < nps_pkg::H_BITS'(2)) begin
			h_wr = nps_pkg::H_BITS'(2);
		end else if (cfg_data[nps_pkg::H_BITS-1:0] > nps_pkg::H_BITS'(nps_pkg::MAX_HEIGHT)) begin
			h_wr = nps_pkg::H_BITS'(nps_pkg::MAX_HEIGHT);
		end else begin
			h_wr = cfg_data[nps_pkg::H_BITS-1:0];
		end
	end

	assign s_tready = occ_q < nps_pkg::OCC_BITS'(nps_pkg::FIFO_DEPTH);
	assign in_acc   = s_tvalid && s_tready;
	assign drain    = row_q >= nps_pkg::ROW_BITS'(h_q);
	// A drain tick inside the sample part of the frame is dropped.
	assign take     = in_acc && (drain || (s_tuser == nps_pkg::OP_SAMPLE));
	assign x_in     = drain ? '0 : s_tdata[nps_pkg::SAMPLE_BITS-1:0];

	// Position of the point whose window this beat completes, one column behind.
	always_comb begin
		j       = ({1'b0, col_q} >= w_q) ? '0 : col_q;
		col_inc = {1'b0, j} + nps_pkg::W_BITS'(1);
		emit    = (row_q >= nps_pkg::ROW_BITS'(2)) ||
			((row_q == nps_pkg::ROW_BITS'(1)) && (j != '0));
		if (j != '0) begin
			r = row_q - nps_pkg::ROW_BITS'(1);
			c = j - nps_pkg::COL_BITS'(1);
		end else begin
			r = row_q - nps_pkg::ROW_BITS'(2);
			c = nps_pkg::COL_BITS'(w_q - nps_pkg::W_BITS'(1));
		end
		flags.use_top   = r != '0;
		flags.use_bot   = r != nps_pkg::ROW_BITS'(h_q - nps_pkg::H_BITS'(1));
		flags.use_left  = c != '0;
		flags.use_right = {1'b0, c} != (w_q - nps_pkg::W_BITS'(1));
		flags.last      = !flags.use_bot && !flags.use_right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= nps_pkg::W_BITS'(1024);
			h_q   <= nps_pkg::H_BITS'(1024);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			unique case (nps_pkg::reg_idx_t'(cfg_index))
				nps_pkg::REG_FRAME_WIDTH:  w_q <= w_wr;
				nps_pkg::REG_FRAME_HEIGHT: h_q <= h_wr;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (emit && flags.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_q) begin
				col_q <= '0;
				row_q <= row_q + nps_pkg::ROW_BITS'(1);
			end else begin
				col_q <= nps_pkg::COL_BITS'(col_inc);
			end
		end
	end

	// Credits cover everything between the input and the queue's output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + nps_pkg::OCC_BITS'(take && emit) - nps_pkg::OCC_BITS'(out_acc);
		end
	end

	// Stage 1: line memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			emit_s1  <= emit;
			flags_s1 <= flags;
			x_s1     <= x_in;
			addr_s1  <= j;
			rd_s1    <= line_mem[j];
		end
	end

	// Write back: the middle row moves up, the new sample becomes the middle row.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[addr_s1] <= '{upper: rd_s1.middle, middle: x_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]     <= win_q[k*3 + 1];
				win_q[k*3 + 1] <= win_q[k*3 + 2];
			end
			win_q[2] <= rd_s1.upper;
			win_q[5] <= rd_s1.middle;
			win_q[8] <= x_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && emit_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		flags_s2 <= flags_s1;
	end

	// Stage 2: masked neighbor terms.
	always_comb begin
		t_tl = (flags_s2.use_top && flags_s2.use_left)  ? nps_pkg::sext(win_q[0]) : '0;
		t_t  = flags_s2.use_top                         ? nps_pkg::sext(win_q[1]) : '0;
		t_tr = (flags_s2.use_top && flags_s2.use_right) ? nps_pkg::sext(win_q[2]) : '0;
		t_l  = flags_s2.use_left                        ? nps_pkg::sext(win_q[3]) : '0;
		t_c  = nps_pkg::sext(win_q[4]);
		t_r  = flags_s2.use_right                       ? nps_pkg::sext(win_q[5]) : '0;
		t_bl = (flags_s2.use_bot && flags_s2.use_left)  ? nps_pkg::sext(win_q[6]) : '0;
		t_b  = flags_s2.use_bot                         ? nps_pkg::sext(win_q[7]) : '0;
		t_br = (flags_s2.use_bot && flags_s2.use_right) ? nps_pkg::sext(win_q[8]) : '0;
	end

	always_ff @(posedge clk) begin
		last_s3 <= flags_s2.last;
		top_s3  <= t_tl + t_t + t_tr;
		bot_s3  <= t_bl + t_b + t_br;
		side_s3 <= t_l + t_r;
		// 26 = 16 + 8 + 2
		cent_s3 <= (t_c <<< 4) + (t_c <<< 3) + (t_c <<< 1);
	end

	// Stage 3: one partial difference and one partial sum.
	always_ff @(posedge clk) begin
		last_s4 <= last_s3;
		a_s4    <= cent_s3 - side_s3;
		b_s4    <= top_s3 + bot_s3;
	end

	// Stage 4 writes the final value into the output queue.
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			fifo_q[wr_ptr_q] <= '{last: last_s4, value: a_s4 - b_s4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s4) begin
				wr_ptr_q <= wr_ptr_q + nps_pkg::FIFO_AW'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + nps_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + nps_pkg::OCC_BITS'(valid_s4) - nps_pkg::OCC_BITS'(out_acc);
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = nps_pkg::M_TDATA_BITS'(unsigned'(fifo_q[rd_ptr_q].value));
	assign m_tlast  = fifo_q[rd_ptr_q].last;

endmodule
`default_nettype wire

[sv/nps_checker.sv]
// Port-level checker for the nine-point stencil block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nps_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic [nps_pkg::S_TDATA_BITS-1:0]   s_tdata,
	input wire logic                               s_tuser,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [nps_pkg::M_TDATA_BITS-1:0]   m_tdata,
	input wire logic                               m_tlast,
	input wire logic                               cfg_we,
	input wire logic [nps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [nps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	// Input beats accepted minus results delivered, saturating at the top.
	logic [15:0] diff_q;
	logic        in_beat;
	logic        out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
		end else if (in_beat && !out_beat && (diff_q != '1)) begin
			diff_q <= diff_q + 16'd1;
		end else if (out_beat && !in_beat && (diff_q != '0)) begin
			diff_q <= diff_q - 16'd1;
		end
	end

	// A held result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// Checks that the input is only stalled while a result waits at the output.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// Every delivered result follows an accepted input beat.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> diff_q != '0)
		else $error("more results than input beats");

	// Once reset has been seen at a clock edge, no result is shown in the next cycle.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	logic unused_ok;
	assign unused_ok = ^{s_tdata, s_tuser, cfg_we, cfg_index, cfg_data};

endmodule

bind nine_point_stencil_2d nps_checker u_nps_checker (.*);
`default_nettype wire
